// ===== design/cams_pkg.sv =====
// Package: shared types and constants for the circular alignment block.
package cams_pkg;

  localparam int FIELD_W = 8;
  localparam int CFG_W   = 8;
  localparam int COST_W  = 29;

  localparam logic [COST_W-1:0] COST_MAX = 29'h1FFF_FFFF;

  typedef struct packed {
    logic [FIELD_W-1:0] first_value;
    logic [FIELD_W-1:0] second_value;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CORR,
    ST_OFFS,
    ST_FINISH
  } state_t;

  // Handshake between the sequencer and one of its arithmetic units.
  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== design/cams_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cams_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cams_corr.sv =====
// Circular cross-correlation maximum: one shared multiply-accumulate, n*n steps.
module cams_corr #(
  parameter int DATA_W = 8,
  parameter int CNT_W  = 11,
  parameter int ADDR_W = 10,
  parameter int CORR_W = 27
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cams_pkg::unit_ctrl_t    ctrl,
  output cams_pkg::unit_stat_t    stat,
  input  logic [CNT_W-1:0]        n,
  output logic [ADDR_W-1:0]       raddr_a,
  output logic [ADDR_W-1:0]       raddr_b,
  input  logic [DATA_W-1:0]       rdata_a,
  input  logic [DATA_W-1:0]       rdata_b,
  output logic [CORR_W-1:0]       best
);

  localparam int PROD_W = 2 * DATA_W;

  logic               issuing;
  logic               busy;
  logic               done;
  logic [ADDR_W-1:0]  i;
  logic [ADDR_W-1:0]  j;
  logic [CNT_W-1:0]   s;
  logic               v1, e1, v2, e2;
  logic [PROD_W-1:0]  prod;
  logic [CORR_W-1:0]  acc;
  logic [CORR_W-1:0]  acc_sum;
  logic               last_i;
  logic               last_j;
  logic               last_s;

  assign last_i  = (CNT_W'(i) + CNT_W'(1)) == n;
  assign last_j  = (CNT_W'(j) + CNT_W'(1)) == n;
  assign last_s  = (s + CNT_W'(1)) == n;
  assign acc_sum = acc + CORR_W'(prod);

  assign raddr_a = i;
  assign raddr_b = j;

  assign stat.busy = busy;
  assign stat.done = done;

  // Address sequencer: i walks the first store, j the second rotated by s.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      busy    <= 1'b0;
      done    <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= issuing;
      v2   <= v1;
      if (ctrl.start) begin
        issuing <= 1'b1;
        busy    <= 1'b1;
      end else if (issuing) begin
        if (last_i && last_s) begin
          issuing <= 1'b0;
        end
      end else if (busy && !v1 && !v2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      i <= '0;
      j <= '0;
      s <= '0;
    end else if (issuing) begin
      if (last_i) begin
        i <= '0;
        s <= s + CNT_W'(1);
        j <= ADDR_W'(s + CNT_W'(1));
      end else begin
        i <= i + ADDR_W'(1);
        j <= last_j ? '0 : j + ADDR_W'(1);
      end
    end
  end

  // Data path: RAM read -> product register -> accumulate and keep the maximum.
  always_ff @(posedge clk) begin
    e1   <= last_i;
    e2   <= e1;
    prod <= PROD_W'(rdata_a) * PROD_W'(rdata_b);
    if (ctrl.start) begin
      acc  <= '0;
      best <= '0;
    end else if (v2) begin
      if (e2) begin
        acc <= '0;
        if (acc_sum > best) begin
          best <= acc_sum;
        end
      end else begin
        acc <= acc_sum;
      end
    end
  end

endmodule

// ===== design/cams_offset.sv =====
// Offset search: walks k = 0..bound with running sums, no multiplier.
module cams_offset #(
  parameter int CNT_W   = 11,
  parameter int SUM_W   = 18,
  parameter int SQSUM_W = 27,
  parameter int V_W     = 47
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cams_pkg::unit_ctrl_t        ctrl,
  output cams_pkg::unit_stat_t        stat,
  input  logic [CNT_W-1:0]            n,
  input  logic [cams_pkg::CFG_W-1:0]  bound,
  input  logic [SUM_W-1:0]            sum_a,
  input  logic [SUM_W-1:0]            sum_b,
  input  logic [SQSUM_W-1:0]          sq_a,
  input  logic [SQSUM_W-1:0]          sq_b,
  output logic signed [V_W-1:0]       best
);

  logic                        running;
  logic                        done;
  logic [cams_pkg::CFG_W-1:0]  k;
  logic signed [V_W-1:0]       q;
  logic signed [V_W-1:0]       inc;
  logic signed [V_W-1:0]       e;
  logic signed [V_W-1:0]       v;
  logic signed [V_W-1:0]       base;
  logic signed [V_W-1:0]       two_n;
  logic signed [V_W-1:0]       estep;
  logic signed [SUM_W:0]       diff;
  logic signed [SUM_W:0]       abs_diff;

  assign base     = $signed(V_W'(sq_a)) + $signed(V_W'(sq_b));
  assign two_n    = $signed(V_W'(n)) <<< 1;
  assign diff     = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});
  assign abs_diff = diff[SUM_W] ? -diff : diff;
  assign estep    = $signed(V_W'(abs_diff)) <<< 1;

  // Offsets +k and -k share n*k^2; the better sign subtracts 2*k*|diff|.
  assign v = q - e;

  assign stat.busy = running;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
      end else if (running && k == bound) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      k   <= '0;
      q   <= base;
      inc <= $signed(V_W'(n));
      e   <= '0;
    end else if (running) begin
      if (k == '0 || v < best) begin
        best <= v;
      end
      q   <= q + inc;
      inc <= inc + two_n;
      e   <= e + estep;
      k   <= k + cams_pkg::CFG_W'(1);
    end
  end

endmodule

// ===== design/circular_align_min_sq_diff.sv =====
// Top level: pair loader, stores, sequencer and result register.
//
// Usage: pairs arrive on in_valid/in_ready, one request per cycle while loading.
// Each accepted pair is written to the two stores and added to the running sums;
// pairs beyond MAX_LEN are dropped and flag overflow in the result. The pair
// with is_last set starts the computation, and in_ready stays low until the
// result is registered. The shared multiply-accumulate walks all n cyclic
// shifts, n*n steps, then the offset walk takes offset_bound + 1 steps over
// the running sums. The computation time is dominated by the n*n correlation
// loop on the single store read port pair.
// One result request is held in an output register until out_ready; loading of
// the next sequence goes on meanwhile, and a finished result waits for the
// register to be free. offset_bound is written on the cfg channel, always
// ready. Synchronous reset clears counts, sums, flags, offset_bound, out_valid;
// out_data and store contents are left undefined, only written entries read.
module circular_align_min_sq_diff #(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cams_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cams_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cams_pkg::CFG_W-1:0]  cfg_data
);

  localparam int DATA_W  = (VALUE_BITS < cams_pkg::FIELD_W) ? VALUE_BITS
                                                             : cams_pkg::FIELD_W;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SQ_W    = 2 * DATA_W;
  localparam int SUM_W   = DATA_W + CNT_W;
  localparam int SQSUM_W = SQ_W + CNT_W;
  localparam int CORR_W  = SQ_W + CNT_W;
  localparam int V_RAW   = SQSUM_W + 2 * cams_pkg::CFG_W + 4;
  localparam int V_W     = (V_RAW > cams_pkg::COST_W + 2) ? V_RAW : cams_pkg::COST_W + 2;

  cams_pkg::state_t            state, state_next;
  cams_pkg::unit_ctrl_t        corr_ctrl, offs_ctrl;
  cams_pkg::unit_stat_t        corr_stat, offs_stat;

  logic [cams_pkg::CFG_W-1:0]  offset_bound;
  logic [CNT_W-1:0]            pair_count;
  logic [SUM_W-1:0]            first_sum, second_sum;
  logic [SQSUM_W-1:0]          first_square_sum, second_square_sum;
  logic                        capacity_exceeded;

  logic                        in_accept;
  logic                        has_room;
  logic                        store_we;
  logic [DATA_W-1:0]           a_val, b_val;
  logic [SQ_W-1:0]             a_sq, b_sq;
  logic [ADDR_W-1:0]           raddr_a, raddr_b;
  logic [DATA_W-1:0]           rdata_a, rdata_b;
  logic [CORR_W-1:0]           best_corr;
  logic signed [V_W-1:0]       best_offs;
  logic signed [V_W-1:0]       full_cost;
  logic [cams_pkg::COST_W-1:0] cost;
  logic                        out_free;
  logic                        finish;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == cams_pkg::ST_LOAD);
  assign in_accept = in_valid && in_ready;
  assign has_room  = pair_count < CNT_W'(MAX_LEN);
  assign store_we  = in_accept && has_room;

  assign a_val = in_data.first_value[DATA_W-1:0];
  assign b_val = in_data.second_value[DATA_W-1:0];
  assign a_sq  = SQ_W'(a_val) * SQ_W'(a_val);
  assign b_sq  = SQ_W'(b_val) * SQ_W'(b_val);

  assign out_free = !out_valid || out_ready;

  cams_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_first_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (pair_count[ADDR_W-1:0]),
    .wdata (a_val),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  cams_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_second_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (pair_count[ADDR_W-1:0]),
    .wdata (b_val),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  cams_corr #(
    .DATA_W (DATA_W),
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W),
    .CORR_W (CORR_W)
  ) u_corr (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (corr_ctrl),
    .stat    (corr_stat),
    .n       (pair_count),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .best    (best_corr)
  );

  cams_offset #(
    .CNT_W   (CNT_W),
    .SUM_W   (SUM_W),
    .SQSUM_W (SQSUM_W),
    .V_W     (V_W)
  ) u_offset (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (offs_ctrl),
    .stat  (offs_stat),
    .n     (pair_count),
    .bound (offset_bound),
    .sum_a (first_sum),
    .sum_b (second_sum),
    .sq_a  (first_square_sum),
    .sq_b  (second_square_sum),
    .best  (best_offs)
  );

  assign full_cost = best_offs - ($signed(V_W'(best_corr)) <<< 1);

  always_comb begin
    if (full_cost[V_W-1]) begin
      cost = '0;
    end else if (full_cost > $signed(V_W'(cams_pkg::COST_MAX))) begin
      cost = cams_pkg::COST_MAX;
    end else begin
      cost = full_cost[cams_pkg::COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cams_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    corr_ctrl.start = 1'b0;
    offs_ctrl.start = 1'b0;
    finish          = 1'b0;
    case (state)
      cams_pkg::ST_LOAD: begin
        if (in_accept && in_data.is_last) begin
          corr_ctrl.start = 1'b1;
          state_next      = cams_pkg::ST_CORR;
        end
      end
      cams_pkg::ST_CORR: begin
        if (corr_stat.done) begin
          offs_ctrl.start = 1'b1;
          state_next      = cams_pkg::ST_OFFS;
        end
      end
      cams_pkg::ST_OFFS: begin
        if (offs_stat.done) begin
          state_next = cams_pkg::ST_FINISH;
        end
      end
      cams_pkg::ST_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = cams_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = cams_pkg::ST_LOAD;
      end
    endcase
  end

  // Sequence accumulators; cleared once the result is in the output register.
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      pair_count        <= '0;
      first_sum         <= '0;
      second_sum        <= '0;
      first_square_sum  <= '0;
      second_square_sum <= '0;
      capacity_exceeded <= 1'b0;
    end else if (in_accept) begin
      if (has_room) begin
        pair_count        <= pair_count + CNT_W'(1);
        first_sum         <= first_sum + SUM_W'(a_val);
        second_sum        <= second_sum + SUM_W'(b_val);
        first_square_sum  <= first_square_sum + SQSUM_W'(a_sq);
        second_square_sum <= second_square_sum + SQSUM_W'(b_sq);
      end else begin
        capacity_exceeded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bound <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset_bound <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.min_cost <= cost;
      out_data.overflow <= capacity_exceeded;
    end
  end

endmodule

// ===== design/cams_check.sv =====
// Port-level checker for the circular alignment block, bound to the top level.
module cams_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input cams_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input cams_pkg::out_item_t  out_data
);

  // A held result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The final pair starts the computation, so no pair is taken next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.is_last |=> !in_ready)
    else $error("input ready right after final pair");

  // A result appears only at the end of a computation.
  a_result_from_compute: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while loading");

  // Reset leaves the block loading with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind circular_align_min_sq_diff cams_check u_cams_check (.*);
